// ===== rtl/core/fbq_pkg.sv =====
// Shared types, constants and helpers for the per-joint feedback biquad block.
`default_nettype none

package fbq_pkg;

  localparam int CHANNELS       = 8;
  localparam int JOINT_W        = 3;
  localparam int COEF_FRAC_BITS = 30;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PTR_W        = 1;
  localparam int ACC_W          = 68;

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  typedef enum logic [2:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_COEF_B0       = 3'd1,
    REG_COEF_A1       = 3'd2,
    REG_COEF_A2       = 3'd3,
    REG_GAIN_SCALE    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] gain;
  } coef_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] fb;
    logic signed [31:0] ff;
    logic               filt;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    if (v < SAT_MIN) r = SAT_MIN;
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbq_front.sv =====
// Input register stage: takes a word, tags it filtered or pass-through, feeds the queue.
`default_nettype none

module fbq_front
  import fbq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               filter_enable,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [JOINT_W-1:0] joint_index,
  input  wire logic signed [31:0] feedback_torque,
  input  wire logic signed [31:0] feedforward_torque,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output item_t                   push_item
);

  logic  fr_valid;
  item_t fr_item;
  logic  in_range;

  assign in_range   = {1'b0, joint_index} < (JOINT_W+1)'(CHANNELS);
  assign in_ready   = !fr_valid || push_ready;
  assign push_valid = fr_valid;
  assign push_item  = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid <= 1'b1;
    end else if (push_ready) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item.joint <= joint_index;
      fr_item.fb    <= feedback_torque;
      fr_item.ff    <= feedforward_torque;
      fr_item.filt  <= filter_enable && in_range;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fbq_queue.sv =====
// Short FIFO between the front stage and the filter pipeline.
`default_nettype none

module fbq_queue
  import fbq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != (Q_PTR_W+1)'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

// ===== rtl/core/fbq_back.sv =====
// Filter pipeline: per-joint biquad state, products, sum, gain scale and feedforward add.
`default_nettype none

module fbq_back
  import fbq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire coef_t              coef,
  input  wire logic               coef_clear,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire item_t              pop_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [JOINT_W-1:0]      out_joint_index,
  output logic signed [31:0]      control_torque
);

  // per-joint delay lines
  logic signed [31:0] x1_mem [CHANNELS];
  logic signed [31:0] x2_mem [CHANNELS];
  logic signed [31:0] y1_mem [CHANNELS];
  logic signed [31:0] y2_mem [CHANNELS];
  logic [CHANNELS-1:0] primed;

  logic adv;
  logic hazard;
  logic issue;

  // issue stage
  logic               pr;
  logic signed [31:0] x;
  logic signed [31:0] x1;
  logic signed [31:0] x2;
  logic signed [31:0] y1;
  logic signed [31:0] y2;
  logic signed [33:0] xsum;

  // product stage
  logic               m_valid;
  logic               m_filt;
  logic [JOINT_W-1:0] m_joint;
  logic signed [31:0] m_fb;
  logic signed [31:0] m_ff;
  logic signed [31:0] m_y1;
  logic signed [65:0] m_pb;
  logic signed [63:0] m_pa1;
  logic signed [63:0] m_pa2;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [31:0]      y;
  logic signed [31:0]      fb_sel;

  // filtered stage
  logic               r1_valid;
  logic [JOINT_W-1:0] r1_joint;
  logic signed [31:0] r1_fb;
  logic signed [31:0] r1_ff;

  // gain product stage
  logic               r2_valid;
  logic [JOINT_W-1:0] r2_joint;
  logic signed [63:0] r2_prod;
  logic signed [31:0] r2_ff;

  logic signed [ACC_W-1:0] g_sh;
  logic signed [31:0]      fb_scaled;
  logic signed [31:0]      total;

  assign adv = !out_valid || out_ready;
  // a1*y[n-1] needs the previous word's sum for the same joint
  assign hazard    = pop_item.filt && m_valid && m_filt && (m_joint == pop_item.joint);
  assign issue     = pop_valid && adv && !hazard;
  assign pop_ready = adv && !hazard;

  always_comb begin
    pr   = primed[pop_item.joint];
    x    = pop_item.fb;
    x1   = pr ? x1_mem[pop_item.joint] : x;
    x2   = pr ? x2_mem[pop_item.joint] : x;
    y1   = pr ? y1_mem[pop_item.joint] : x;
    y2   = pr ? y2_mem[pop_item.joint] : x;
    xsum = 34'(x) + (34'(x1) <<< 1) + 34'(x2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= issue;
      r1_valid  <= m_valid;
      r2_valid  <= r1_valid;
      out_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (coef_clear) begin
      primed <= '0;
    end else if (issue && pop_item.filt) begin
      primed[pop_item.joint] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && pop_item.filt) begin
      x2_mem[pop_item.joint] <= x1;
      x1_mem[pop_item.joint] <= x;
    end
    if (adv && m_valid && m_filt) begin
      y2_mem[m_joint] <= m_y1;
      y1_mem[m_joint] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_filt  <= pop_item.filt;
      m_joint <= pop_item.joint;
      m_fb    <= x;
      m_ff    <= pop_item.ff;
      m_y1    <= y1;
      m_pb    <= 66'(coef.b0) * 66'(xsum);
      m_pa1   <= 64'(coef.a1) * 64'(y1);
      m_pa2   <= 64'(coef.a2) * 64'(y2);
    end
  end

  always_comb begin
    acc    = ACC_W'(m_pb) - ACC_W'(m_pa1) - ACC_W'(m_pa2) + HALF;
    acc_sh = acc >>> COEF_FRAC_BITS;
    y      = sat32(acc_sh);
    fb_sel = m_filt ? y : m_fb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_joint <= m_joint;
      r1_fb    <= fb_sel;
      r1_ff    <= m_ff;
      r2_joint <= r1_joint;
      r2_prod  <= 64'(r1_fb) * 64'(coef.gain);
      r2_ff    <= r1_ff;
    end
  end

  always_comb begin
    g_sh      = (ACC_W'(r2_prod) + HALF) >>> COEF_FRAC_BITS;
    fb_scaled = sat32(g_sh);
    total     = sat32(ACC_W'(r2_ff) + ACC_W'(fb_scaled));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_joint_index <= r2_joint;
      control_torque  <= total;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multichannel_feedback_biquad_lowpass_top.sv =====
// Top level: configuration registers, front stage, queue and filter pipeline.
//
//   channel   direction  handshake             payload
//   in        to block   in_valid/in_ready     joint_index, feedback_torque, feedforward_torque
//   out       from block out_valid/out_ready   out_joint_index, control_torque
//   cfg       to block   cfg_write_enable      cfg_index, cfg_data
//
// One word per cycle unless the output stalls. A filtered word for the same joint as the filtered
// word issued just before it waits until that word leaves the product register: the a1*y[n-1]
// loop runs through the product register and the sum stage. Reset clears all valids, the
// per-joint primed bits and the registers (gain = 1.0). An output stall freezes the pipeline;
// the front stage and the two-entry queue take up to three more words, then in_ready drops
// until the output drains.
`default_nettype none

module multichannel_feedback_biquad_lowpass_top
  import fbq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [JOINT_W-1:0] joint_index,
  input  wire logic signed [31:0] feedback_torque,
  input  wire logic signed [31:0] feedforward_torque,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [JOINT_W-1:0]      out_joint_index,
  output logic signed [31:0]      control_torque
);

  logic  filter_enable;
  coef_t coef;
  logic  coef_clear;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  assign coef_clear = cfg_write_enable &&
                      (cfg_index == REG_COEF_B0 || cfg_index == REG_COEF_A1 ||
                       cfg_index == REG_COEF_A2);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      coef.b0       <= '0;
      coef.a1       <= '0;
      coef.a2       <= '0;
      coef.gain     <= 32'(64'sd1 <<< COEF_FRAC_BITS);
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_COEF_B0:       coef.b0       <= cfg_data;
        REG_COEF_A1:       coef.a1       <= cfg_data;
        REG_COEF_A2:       coef.a2       <= cfg_data;
        REG_GAIN_SCALE:    coef.gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  fbq_front u_front (
    .clk                (clk),
    .rst                (rst),
    .filter_enable      (filter_enable),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .joint_index        (joint_index),
    .feedback_torque    (feedback_torque),
    .feedforward_torque (feedforward_torque),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_item          (push_item)
  );

  fbq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fbq_back u_back (
    .clk             (clk),
    .rst             (rst),
    .coef            (coef),
    .coef_clear      (coef_clear),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_joint_index (out_joint_index),
    .control_torque  (control_torque)
  );

endmodule

`default_nettype wire
